// ----- rtl/ffaa_pkg.sv -----
package ffaa_pkg;

   localparam int MAX_SEGMENTS_DEF = 64;
   localparam int MIN_SPLIT_DEF    = 32;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_NO_ARENA = 3'd1;
   localparam logic [2:0] ST_BAD_SIZE = 3'd2;
   localparam logic [2:0] ST_ASYNC    = 3'd3;
   localparam logic [2:0] ST_NO_FIT   = 3'd4;
   localparam logic [2:0] ST_FULL     = 3'd5;
   localparam logic [2:0] ST_BAD_PTR  = 3'd6;

   localparam logic [1:0] CSR_BASE   = 2'd0;
   localparam logic [1:0] CSR_SIZE   = 2'd1;
   localparam logic [1:0] CSR_BUDGET = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_SCAN_RD,
      S_SCAN,
      S_UP_RD,
      S_UP_WR,
      S_SPLIT,
      S_NEXT_RD,
      S_NEXT,
      S_DOWN_RD,
      S_DOWN_WR,
      S_PREV_RD,
      S_PREV,
      S_DONE
   } state_type;

   function automatic logic [34:0] round8(input logic [31:0] v);
      logic [34:0] t;
      t = {3'd0, v} + 35'd7;
      return {t[34:3], 3'd0};
   endfunction

endpackage

// ----- rtl/ffaa_ram.sv -----
module ffaa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ----- rtl/first_fit_arena_allocator.sv -----
// First-fit arena allocator with coalescing over an offset-ordered segment table.
// Configuration: csr_we writes csr_index (0 arena base, 1 arena length,
// 2 async budget) with csr_wdata; write only while no request is in flight.
// Writing a nonzero arena length rebuilds the table as one free segment; a zero
// length empties it. Either write clears the async usage count.
// Requests enter on req_valid/req_ready; one response per request leaves on
// rsp_valid/rsp_ready. One request is processed at a time: req_ready is low
// from acceptance until the block returns to idle.
// Each segment scanned passes a read state and a check state, and each table
// entry moved on a split or merge passes a read state and a write state; with
// no arena the request goes straight to the response. The block returns to
// idle as it loads the response and can then take the next request. All scan
// and move steps go through the single read and single write port of the
// table memory.
// Reset empties the table (no arena). A stalled response holds in the output
// register; the block finishes the next request and then waits for rsp_ready.
module first_fit_arena_allocator #(
   parameter int MAX_SEGMENTS = ffaa_pkg::MAX_SEGMENTS_DEF,
   parameter int MIN_SPLIT    = ffaa_pkg::MIN_SPLIT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_type,
   input  logic [31:0] req_data_bytes,
   input  logic [31:0] req_offsets_bytes,
   input  logic [31:0] req_extra_bytes,
   input  logic        req_oneway,
   input  logic [63:0] req_free_addr,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [63:0] rsp_buffer_addr,
   output logic [31:0] rsp_segment_bytes
);
   import ffaa_pkg::*;

   localparam int AW = $clog2(MAX_SEGMENTS);
   localparam int CW = $clog2(MAX_SEGMENTS + 1);
   localparam int EW = 66;

   state_type state_ff, state_in;

   logic [63:0] base_ff, base_in;
   logic [31:0] size_ff, size_in;
   logic [31:0] budget_ff, budget_in;
   logic [CW-1:0] count_ff, count_in;
   logic [31:0] ause_ff, ause_in;

   logic        op_ff, op_in;
   logic        as_ff, as_in;
   logic [34:0] need_ff, need_in;
   logic [63:0] addr_ff, addr_in;
   logic [31:0] off_ff, off_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] k_ff, k_in;
   logic [31:0] cur_off_ff, cur_off_in;
   logic [31:0] cur_len_ff, cur_len_in;
   logic        phase_ff, phase_in;
   logic [2:0]  st_ff, st_in;
   logic [63:0] res_addr_ff, res_addr_in;
   logic [31:0] res_len_ff, res_len_in;
   logic        rv_ff, rv_in;
   logic [2:0]  out_st_ff, out_st_in;
   logic [63:0] out_addr_ff, out_addr_in;
   logic [31:0] out_len_ff, out_len_in;

   logic          tbl_we;
   logic [AW-1:0] tbl_waddr;
   logic [EW-1:0] tbl_wdata;
   logic          init_we;
   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [EW-1:0] wr_data, rd_data;
   logic [31:0]   rd_off, rd_len;
   logic          rd_free, rd_as;

   logic [34:0] need_sum;
   logic [64:0] fdiff;
   logic [2:0]  check_st;
   logic        check_fail;
   logic        no_arena;
   logic        fit;
   logic [31:0] spare;
   logic        split;

   assign rd_off  = rd_data[65:34];
   assign rd_len  = rd_data[33:2];
   assign rd_free = rd_data[1];
   assign rd_as   = rd_data[0];

   assign init_we = csr_we && csr_index == CSR_SIZE && csr_wdata[31:0] != '0;
   assign wr_en   = tbl_we || init_we;
   assign wr_addr = init_we ? '0 : tbl_waddr;
   assign wr_data = init_we ? {32'd0, csr_wdata[31:0], 1'b1, 1'b0} : tbl_wdata;

   ffaa_ram #(.WIDTH(EW), .DEPTH(MAX_SEGMENTS)) u_table (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   assign need_sum = round8(req_data_bytes) + round8(req_offsets_bytes)
                   + round8(req_extra_bytes);
   assign fdiff    = {1'b0, addr_ff} - {1'b0, base_ff};
   assign no_arena = (size_ff == '0) || (count_ff == '0);
   assign fit      = rd_free && ({3'd0, rd_len} >= need_ff);
   assign spare    = rd_len - need_ff[31:0];
   assign split    = spare >= 32'(MIN_SPLIT);

   always_comb begin
      check_st = ST_OK;
      if (!op_ff) begin
         if (need_ff == '0 || need_ff > {3'd0, size_ff}) begin
            check_st = ST_BAD_SIZE;
         end else if (as_ff && (ause_ff > budget_ff ||
                      need_ff > {3'd0, budget_ff - ause_ff})) begin
            check_st = ST_ASYNC;
         end
      end else if (fdiff[64] || fdiff[63:0] >= {32'd0, size_ff}) begin
         check_st = ST_BAD_PTR;
      end
   end
   assign check_fail = check_st != ST_OK;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = no_arena ? S_DONE : S_CHECK;
            end
         end
         S_CHECK:   state_in = check_fail ? S_DONE : S_SCAN_RD;
         S_SCAN_RD: state_in = (idx_ff >= count_ff) ? S_DONE : S_SCAN;
         S_SCAN: begin
            if (!op_ff) begin
               if (!fit) begin
                  state_in = S_SCAN_RD;
               end else if (!split || count_ff >= CW'(MAX_SEGMENTS)) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_UP_RD;
               end
            end else begin
               if (rd_off < off_ff) begin
                  state_in = S_SCAN_RD;
               end else if (rd_off != off_ff || rd_free) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_NEXT_RD;
               end
            end
         end
         S_UP_RD:   state_in = (k_ff <= idx_ff + CW'(1)) ? S_SPLIT : S_UP_WR;
         S_UP_WR:   state_in = S_UP_RD;
         S_SPLIT:   state_in = S_DONE;
         S_NEXT_RD: state_in = (idx_ff + CW'(1) >= count_ff) ? S_PREV_RD : S_NEXT;
         S_NEXT:    state_in = rd_free ? S_DOWN_RD : S_PREV_RD;
         S_DOWN_RD: begin
            if (k_ff + CW'(1) >= count_ff) begin
               state_in = phase_ff ? S_DONE : S_PREV_RD;
            end else begin
               state_in = S_DOWN_WR;
            end
         end
         S_DOWN_WR: state_in = S_DOWN_RD;
         S_PREV_RD: state_in = (idx_ff == '0) ? S_DONE : S_PREV;
         S_PREV:    state_in = rd_free ? S_DOWN_RD : S_DONE;
         S_DONE: begin
            if (!rv_ff || rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default:   state_in = S_IDLE;
      endcase
   end

   always_comb begin
      base_in = base_ff; size_in = size_ff; budget_in = budget_ff;
      count_in = count_ff; ause_in = ause_ff;
      op_in = op_ff; as_in = as_ff; need_in = need_ff; addr_in = addr_ff;
      off_in = off_ff; idx_in = idx_ff; k_in = k_ff;
      cur_off_in = cur_off_ff; cur_len_in = cur_len_ff; phase_in = phase_ff;
      st_in = st_ff; res_addr_in = res_addr_ff; res_len_in = res_len_ff;
      rv_in = rv_ff; out_st_in = out_st_ff; out_addr_in = out_addr_ff;
      out_len_in = out_len_ff;
      tbl_we = 1'b0;
      tbl_waddr = AW'(idx_ff);
      tbl_wdata = {cur_off_ff, cur_len_ff, 1'b1, 1'b0};
      rd_addr = AW'(idx_ff);
      if (rv_ff && rsp_ready) begin
         rv_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in = req_type; as_in = req_oneway; need_in = need_sum;
               addr_in = req_free_addr; idx_in = '0; phase_in = 1'b0;
               st_in = no_arena ? ST_NO_ARENA : ST_OK;
               res_addr_in = '0; res_len_in = '0;
            end
         end
         S_CHECK: begin
            off_in = fdiff[31:0];
            st_in = check_st;
         end
         S_SCAN_RD: begin
            if (idx_ff >= count_ff) begin
               st_in = op_ff ? ST_BAD_PTR : ST_NO_FIT;
            end
         end
         S_SCAN: begin
            if (!op_ff) begin
               if (!fit) begin
                  idx_in = idx_ff + CW'(1);
               end else if (split && count_ff >= CW'(MAX_SEGMENTS)) begin
                  st_in = ST_FULL;
               end else begin
                  tbl_we = 1'b1;
                  tbl_wdata = {rd_off, split ? need_ff[31:0] : rd_len, 1'b0, as_ff};
                  res_addr_in = base_ff + {32'd0, rd_off};
                  res_len_in = split ? need_ff[31:0] : rd_len;
                  cur_off_in = rd_off; cur_len_in = rd_len;
                  if (as_ff) begin
                     ause_in = ause_ff + need_ff[31:0];
                  end
                  if (split) begin
                     k_in = count_ff;
                     count_in = count_ff + CW'(1);
                  end
               end
            end else begin
               if (rd_off < off_ff) begin
                  idx_in = idx_ff + CW'(1);
               end else if (rd_off != off_ff || rd_free) begin
                  st_in = ST_BAD_PTR;
               end else begin
                  tbl_we = 1'b1;
                  tbl_wdata = {rd_off, rd_len, 1'b1, 1'b0};
                  res_addr_in = addr_ff; res_len_in = rd_len;
                  cur_off_in = rd_off; cur_len_in = rd_len;
                  if (rd_as) begin
                     ause_in = (ause_ff > rd_len) ? ause_ff - rd_len : '0;
                  end
               end
            end
         end
         S_UP_RD: begin
            if (k_ff > idx_ff + CW'(1)) begin
               rd_addr = AW'(k_ff - CW'(1));
            end
         end
         S_UP_WR: begin
            tbl_we = 1'b1;
            tbl_waddr = AW'(k_ff);
            tbl_wdata = rd_data;
            k_in = k_ff - CW'(1);
         end
         S_SPLIT: begin
            tbl_we = 1'b1;
            tbl_waddr = AW'(idx_ff + CW'(1));
            tbl_wdata = {cur_off_ff + need_ff[31:0], cur_len_ff - need_ff[31:0],
                         1'b1, 1'b0};
         end
         S_NEXT_RD: rd_addr = AW'(idx_ff + CW'(1));
         S_NEXT: begin
            if (rd_free) begin
               tbl_we = 1'b1;
               tbl_wdata = {cur_off_ff, cur_len_ff + rd_len, 1'b1, 1'b0};
               cur_len_in = cur_len_ff + rd_len;
               k_in = idx_ff + CW'(1);
            end
         end
         S_DOWN_RD: begin
            if (k_ff + CW'(1) >= count_ff) begin
               count_in = count_ff - CW'(1);
            end else begin
               rd_addr = AW'(k_ff + CW'(1));
            end
         end
         S_DOWN_WR: begin
            tbl_we = 1'b1;
            tbl_waddr = AW'(k_ff);
            tbl_wdata = rd_data;
            k_in = k_ff + CW'(1);
         end
         S_PREV_RD: begin
            if (idx_ff != '0) begin
               rd_addr = AW'(idx_ff - CW'(1));
            end
         end
         S_PREV: begin
            if (rd_free) begin
               tbl_we = 1'b1;
               tbl_waddr = AW'(idx_ff - CW'(1));
               tbl_wdata = {rd_off, rd_len + cur_len_ff, 1'b1, 1'b0};
               k_in = idx_ff;
               phase_in = 1'b1;
            end
         end
         S_DONE: begin
            if (!rv_ff || rsp_ready) begin
               rv_in = 1'b1;
               out_st_in = st_ff;
               out_addr_in = res_addr_ff;
               out_len_in = res_len_ff;
            end
         end
         default: ;
      endcase
      if (csr_we) begin
         case (csr_index)
            CSR_BASE:   base_in = csr_wdata;
            CSR_SIZE: begin
               size_in = csr_wdata[31:0];
               ause_in = '0;
               count_in = (csr_wdata[31:0] == '0) ? '0 : CW'(1);
            end
            CSR_BUDGET: budget_in = csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         base_ff <= '0; size_ff <= '0; budget_ff <= '0;
         count_ff <= '0; ause_ff <= '0; rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         base_ff <= base_in; size_ff <= size_in; budget_ff <= budget_in;
         count_ff <= count_in; ause_ff <= ause_in; rv_ff <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in; as_ff <= as_in; need_ff <= need_in; addr_ff <= addr_in;
      off_ff <= off_in; idx_ff <= idx_in; k_ff <= k_in;
      cur_off_ff <= cur_off_in; cur_len_ff <= cur_len_in; phase_ff <= phase_in;
      st_ff <= st_in; res_addr_ff <= res_addr_in; res_len_ff <= res_len_in;
      out_st_ff <= out_st_in; out_addr_ff <= out_addr_in; out_len_ff <= out_len_in;
   end

   assign req_ready         = (state_ff == S_IDLE);
   assign rsp_valid         = rv_ff;
   assign rsp_status        = out_st_ff;
   assign rsp_buffer_addr   = out_addr_ff;
   assign rsp_segment_bytes = out_len_ff;

   property p_hold;
      @(posedge clock) disable iff (reset)
         rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_buffer_addr) && $stable(rsp_segment_bytes);
   endproperty
   a_hold: assert property (p_hold) else $error("response dropped");

   property p_err_zero;
      @(posedge clock) disable iff (reset)
         rsp_valid && rsp_status != ST_OK |->
            rsp_segment_bytes == '0 && rsp_buffer_addr == '0;
   endproperty
   a_err_zero: assert property (p_err_zero) else $error("error with payload");

   property p_busy;
      @(posedge clock) disable iff (reset)
         state_ff != S_IDLE |-> !req_ready;
   endproperty
   a_busy: assert property (p_busy) else $error("ready while busy");

   property p_count;
      @(posedge clock) disable iff (reset)
         count_ff <= CW'(MAX_SEGMENTS);
   endproperty
   a_count: assert property (p_count) else $error("segment count overflow");
endmodule
